// File: hdl/csr_sparse_matrix_engine_top_defines.svh
// Assertion macros shared by the sparse matrix engine RTL files.
// Define ASSERT_OFF to compile every assertion away.
`ifndef CSR_SPARSE_MATRIX_ENGINE_TOP_DEFINES_SVH
`define CSR_SPARSE_MATRIX_ENGINE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m: label");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: hdl/csme_pkg.sv
// Package for the sparse matrix engine: store sizes, action codes, status codes and
// sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csme_pkg;
   localparam int MAX_ROWS     = 1024;
   localparam int MAX_NONZEROS = 8192;
   localparam int VALUE_BITS   = 32;
   typedef enum logic [2:0] {
      ACT_LOAD_PTR = 3'd0, ACT_LOAD_ENTRY = 3'd1, ACT_LOAD_VEC = 3'd2,
      ACT_ROW_PRODUCT = 3'd3, ACT_LOOKUP = 3'd4, ACT_UNIT_ROW = 3'd5
   } action_type;
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_ROW_RANGE = 2'd1;
   localparam logic [1:0] STATUS_LOAD_RANGE = 2'd2;
   typedef enum logic [3:0] {
      ST_IDLE, ST_PTR0, ST_PTR1, ST_PTR2, ST_FETCH, ST_COL, ST_VEC, ST_MUL, ST_PROD,
      ST_ACC, ST_FINISH, ST_SHIFT, ST_OUT
   } state_type;
endpackage
`default_nettype wire

// File: hdl/csme_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module csme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: hdl/csme_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, saturating 64-bit sum.
// Depends on nothing but the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "csr_sparse_matrix_engine_top_defines.svh"
module csme_mac #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         clear,
   input  wire logic                         mul_en,
   input  wire logic                         acc_en,
   input  wire logic signed [VALUE_BITS-1:0] a,
   input  wire logic signed [VALUE_BITS-1:0] b,
   output logic signed [63:0]                acc
);
   logic signed [63:0] prod_ff, acc_ff, acc_in;
   logic signed [64:0] sum;
   always_comb begin
      sum = {acc_ff[63], acc_ff} + {prod_ff[63], prod_ff};
      if (sum[64] != sum[63]) begin
         acc_in = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         acc_in = sum[63:0];
      end
   end
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= 64'(a * b);
      end
      if (reset || clear) begin
         acc_ff <= '0;
      end else if (acc_en) begin
         acc_ff <= acc_in;
      end
   end
   assign acc = acc_ff;
   `ASSERT_NEVER(a_no_clear_and_acc, clock, reset, clear && acc_en)
   `ASSERT_CLK(a_clear_zero, clock, reset, clear |=> acc_ff == 64'sd0)
   `ASSERT_CLK(a_hold, clock, reset, (!clear && !acc_en) |=> $stable(acc_ff))
endmodule
`default_nettype wire

// File: hdl/csr_sparse_matrix_engine_top.sv
// Top level of the CSR sparse matrix engine: sequencer, four stores and the shared MAC.
// Depends on csme_pkg, csme_ram, csme_mac and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "csr_sparse_matrix_engine_top_defines.svh"
// Each request word is taken only while the engine is idle and yields one response word.
// Loads and out-of-range requests go from ST_PTR0 straight to ST_OUT. Row product, lookup and
// unit row read the two row bounds from the row pointer RAM (ST_PTR0 to ST_FETCH) and then walk
// the row one nonzero at a time through the single read port of the entry RAMs: a product takes
// each nonzero through ST_COL, ST_VEC, ST_MUL, ST_PROD and ST_ACC, using the shared multiply-
// accumulate unit, lookup and unit row through ST_COL and ST_VEC, with lookup stopping at the first match.
module csr_sparse_matrix_engine_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [10:0] csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // action[2:0], position[15:3], row[25:16], column[35:26], pointer[49:36],
   // number[81:50], zero fill to 88 bits.
   input  wire logic [87:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], result[33:2], found[34], entry_address[47:35].
   output logic [47:0]      rsp_tdata
);
   import csme_pkg::*;
   localparam int RA = $clog2(MAX_ROWS + 1);
   localparam int VA = $clog2(MAX_ROWS);
   localparam int NA = $clog2(MAX_NONZEROS);

   state_type state_ff, state_in;
   logic [10:0] rows_ff;
   logic [2:0]  act_ff;
   logic [12:0] pos_ff;
   logic [9:0]  row_ff, col_ff;
   logic [13:0] ptr_ff;
   logic [31:0] num_ff;
   logic [14:0] idx_ff, idx_in, end_ff, end_in;
   logic [1:0]  st_ff, st_in;
   logic [31:0] res_ff, res_in;
   logic        fnd_ff, fnd_in;
   logic [12:0] adr_ff, adr_in;
   logic        rsp_v_ff;
   logic signed [VALUE_BITS-1:0] ev_ff, vv_ff;

   logic [RA-1:0] rp_raddr;
   logic [13:0]   rp_rdata;
   logic          rp_we, ev_we, ec_we, dv_we;
   logic [NA-1:0] e_raddr, e_waddr;
   logic [9:0]    ec_rdata;
   logic [VALUE_BITS-1:0] ev_rdata, ev_wdata, dv_rdata;
   logic [VA-1:0] dv_raddr;
   logic          mclr, mmul, macc;
   logic signed [63:0] acc;
   logic signed [47:0] sh;
   logic [14:0] clamp;
   logic        row_ok;

   csme_ram #(.WIDTH(14), .DEPTH(MAX_ROWS + 1)) u_rp (
      .clock, .wr_en(rp_we), .wr_addr(RA'(pos_ff)), .wr_data(ptr_ff),
      .rd_addr(rp_raddr), .rd_data(rp_rdata));
   csme_ram #(.WIDTH(10), .DEPTH(MAX_NONZEROS)) u_ec (
      .clock, .wr_en(ec_we), .wr_addr(e_waddr), .wr_data(col_ff),
      .rd_addr(e_raddr), .rd_data(ec_rdata));
   csme_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_NONZEROS)) u_ev (
      .clock, .wr_en(ev_we), .wr_addr(e_waddr), .wr_data(ev_wdata),
      .rd_addr(e_raddr), .rd_data(ev_rdata));
   csme_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ROWS)) u_dv (
      .clock, .wr_en(dv_we), .wr_addr(VA'(col_ff)), .wr_data(VALUE_BITS'(num_ff)),
      .rd_addr(dv_raddr), .rd_data(dv_rdata));
   csme_mac #(.VALUE_BITS(VALUE_BITS)) u_mac (
      .clock, .reset, .clear(mclr), .mul_en(mmul), .acc_en(macc),
      .a(ev_ff), .b(vv_ff), .acc);

   assign req_tready = (state_ff == ST_IDLE) && !rsp_v_ff;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {adr_ff, fnd_ff, res_ff, st_ff};
   assign row_ok = (11'(row_ff) < rows_ff) && (32'(row_ff) < MAX_ROWS);
   assign clamp = (32'(rp_rdata) > MAX_NONZEROS) ? 15'(MAX_NONZEROS) : 15'(rp_rdata);
   assign e_raddr = NA'(idx_ff);
   assign dv_raddr = VA'(ec_rdata);
   assign sh = 48'(acc >>> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff  <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            rows_ff <= csr_wr_data;
         end
         if (state_ff == ST_OUT) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end
      if (req_tvalid && req_tready) begin
         act_ff <= req_tdata[2:0];
         pos_ff <= req_tdata[15:3];
         row_ff <= req_tdata[25:16];
         col_ff <= req_tdata[35:26];
         ptr_ff <= req_tdata[49:36];
         num_ff <= req_tdata[81:50];
      end
      idx_ff <= idx_in;
      end_ff <= end_in;
      st_ff  <= st_in;
      res_ff <= res_in;
      fnd_ff <= fnd_in;
      adr_ff <= adr_in;
      ev_ff  <= ev_rdata;
      vv_ff  <= (32'(ec_rdata) < MAX_ROWS) ? dv_rdata : '0;
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff; end_in = end_ff;
      st_in = st_ff; res_in = res_ff; fnd_in = fnd_ff; adr_in = adr_ff;
      rp_raddr = RA'(row_ff);
      rp_we = 1'b0; ec_we = 1'b0; ev_we = 1'b0; dv_we = 1'b0;
      e_waddr = NA'(pos_ff);
      ev_wdata = VALUE_BITS'(num_ff);
      mclr = 1'b0; mmul = 1'b0; macc = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !rsp_v_ff) begin
               state_in = ST_PTR0;
            end
         end
         ST_PTR0: begin
            st_in = STATUS_OK; res_in = '0; fnd_in = 1'b0; adr_in = '0;
            mclr = 1'b1;
            state_in = ST_OUT;
            case (act_ff)
               ACT_LOAD_PTR: begin
                  if (32'(pos_ff) > MAX_ROWS) st_in = STATUS_LOAD_RANGE;
                  else rp_we = 1'b1;
               end
               ACT_LOAD_ENTRY: begin
                  if (32'(pos_ff) >= MAX_NONZEROS) st_in = STATUS_LOAD_RANGE;
                  else begin
                     ec_we = 1'b1; ev_we = 1'b1;
                  end
               end
               ACT_LOAD_VEC: begin
                  if (32'(col_ff) >= MAX_ROWS) st_in = STATUS_LOAD_RANGE;
                  else dv_we = 1'b1;
               end
               ACT_ROW_PRODUCT, ACT_LOOKUP, ACT_UNIT_ROW: begin
                  if (!row_ok) st_in = STATUS_ROW_RANGE;
                  else state_in = ST_PTR1;
               end
               default: ;
            endcase
         end
         ST_PTR1: begin
            rp_raddr = RA'(row_ff + 11'd1);
            idx_in = clamp;
            state_in = ST_PTR2;
         end
         ST_PTR2: begin
            rp_raddr = RA'(row_ff + 11'd1);
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            end_in = (clamp < idx_ff) ? idx_ff : clamp;
            state_in = ST_COL;
         end
         ST_COL: begin
            if (idx_ff >= end_ff) state_in = ST_FINISH;
            else state_in = ST_VEC;
         end
         ST_VEC: begin
            if (act_ff == ACT_ROW_PRODUCT) state_in = ST_MUL;
            else if (act_ff == ACT_LOOKUP) begin
               if (ec_rdata == col_ff) begin
                  fnd_in = 1'b1; adr_in = 13'(idx_ff); res_in = 32'(ev_rdata);
                  state_in = ST_OUT;
               end else begin
                  idx_in = idx_ff + 15'd1; state_in = ST_COL;
               end
            end else begin
               e_waddr = NA'(idx_ff);
               ev_we = 1'b1;
               ev_wdata = (ec_rdata == row_ff) ? VALUE_BITS'(32'h10000) : '0;
               idx_in = idx_ff + 15'd1; state_in = ST_COL;
            end
         end
         ST_MUL: begin
            state_in = ST_PROD;
         end
         ST_PROD: begin
            mmul = 1'b1; state_in = ST_ACC;
         end
         ST_ACC: begin
            macc = 1'b1; idx_in = idx_ff + 15'd1; state_in = ST_COL;
         end
         ST_FINISH: begin
            state_in = (act_ff == ACT_ROW_PRODUCT) ? ST_SHIFT : ST_OUT;
         end
         ST_SHIFT: begin
            if (sh > 48'sh7FFFFFFF) res_in = 32'h7FFFFFFF;
            else if (sh < -48'sh80000000) res_in = 32'h80000000;
            else res_in = 32'(sh);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `ASSERT_CLK(a_accept_idle, clock, reset, (req_tvalid && req_tready) |-> !rsp_v_ff)
   `ASSERT_CLK(a_out_valid, clock, reset, (state_ff == ST_OUT) |=> rsp_tvalid)
   `ASSERT_NEVER(a_walk_bound, clock, reset, (state_ff == ST_MUL) && (idx_ff >= end_ff))
endmodule
`default_nettype wire
